// File: hw/rtl/jod_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON object deframer package
// Shared constants, status codes and the structs passed between the framer
// core, the output buffer and the top level.
// ----------------------------------------------------------------------------
package jod_pkg;

   localparam int unsigned MAX_NESTING = 255;
   localparam int unsigned LENGTH_BITS = 16;
   localparam int unsigned DEPTH_BITS  = $clog2(MAX_NESTING + 1);

   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [DEPTH_BITS-1:0]  DEPTH_MAX  = DEPTH_BITS'(MAX_NESTING);

   localparam logic [7:0] CH_OPEN   = 8'h7B;
   localparam logic [7:0] CH_CLOSE  = 8'h7D;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;

   typedef enum logic [1:0] {
      STATUS_DISCARD = 2'd0,
      STATUS_BODY    = 2'd1,
      STATUS_END     = 2'd2,
      STATUS_ABORT   = 2'd3
   } status_type;

   typedef struct packed {
      logic [7:0] data;
      status_type status;
   } result_type;

   typedef struct packed {
      logic                  in_frame;
      logic                  in_string;
      logic [DEPTH_BITS-1:0] depth;
   } frame_state_type;

endpackage
`default_nettype wire

// File: hw/rtl/json_object_deframer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON object deframer
// Finds complete top-level JSON objects in a byte stream by brace counting
// and tags every byte as discarded, frame body, frame end or frame abort.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_stall   req_data_byte
//   rsp_      out        rsp_valid/rsp_stall   rsp_out_byte, rsp_byte_status
//   csr_      in         csr_write_enable      csr_write_data
//
// One request is taken every cycle while req_stall is low; each response
// is registered. The frame state updates per request, which sets the rate.
// Reset is synchronous and clears the frame state and the length limit.
// A stalled response is held in the result register and one more request
// goes to a skid entry; req_stall rises only while that entry is full.
// ----------------------------------------------------------------------------
module json_object_deframer
   import jod_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_out_byte,
   output logic [1:0]       rsp_byte_status,
   input  wire logic        csr_write_enable,
   input  wire logic [15:0] csr_write_data
);

   logic            push;
   logic            full;
   result_type      core_result;
   result_type      out_data;
   frame_state_type frame_state;

   assign push      = req_valid && !full;
   assign req_stall = full;

   jod_framer_core u_core (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .data_byte        (req_data_byte),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .result           (core_result),
      .frame_state      (frame_state)
   );

   jod_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (core_result),
      .full      (full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_out_byte    = out_data.data;
   assign rsp_byte_status = out_data.status;

`ifndef ASSERT_OFF
   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("skid entry full without a pending response");

   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no response");

   a_idle_state_clear: assert property (@(posedge clock) disable iff (reset)
      !frame_state.in_frame |-> (frame_state.depth == '0 && !frame_state.in_string))
      else $error("frame state not cleared outside a frame");

   a_frame_has_depth: assert property (@(posedge clock) disable iff (reset)
      frame_state.in_frame |-> (frame_state.depth != '0))
      else $error("open frame with zero brace depth");
`endif

endmodule
`default_nettype wire

// File: hw/rtl/jod_framer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON object deframer core
// Holds the frame state and the length limit register and classifies each
// request byte as discarded, frame body, frame end or frame abort.
// ----------------------------------------------------------------------------
module jod_framer_core
   import jod_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire logic [7:0]             data_byte,
   input  wire logic                   csr_write_enable,
   input  wire logic [15:0]            csr_write_data,
   output result_type                  result,
   output frame_state_type             frame_state
);

   logic                   in_frame_ff, in_frame_in;
   logic                   in_string_ff, in_string_in;
   logic                   prev_bslash_ff, prev_bslash_in;
   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [LENGTH_BITS-1:0] length_ff, length_in;
   logic [15:0]            max_length_ff;

   logic [LENGTH_BITS-1:0] length_inc;
   logic                   limit_hit;
   logic                   open_limit_hit;
   status_type             status;

   assign length_inc = (length_ff == LENGTH_MAX) ? length_ff
                                                 : length_ff + LENGTH_BITS'(1);
   assign limit_hit = (max_length_ff != 16'd0) &&
                      ({16'd0, length_inc} >= {{LENGTH_BITS{1'b0}}, max_length_ff});
   assign open_limit_hit = (max_length_ff == 16'd1);

   always_comb begin
      in_frame_in    = in_frame_ff;
      in_string_in   = in_string_ff;
      prev_bslash_in = prev_bslash_ff;
      depth_in       = depth_ff;
      length_in      = length_ff;
      status         = STATUS_DISCARD;
      if (!in_frame_ff) begin
         if (data_byte == CH_OPEN) begin
            if (open_limit_hit) begin
               status = STATUS_ABORT;
            end else begin
               status         = STATUS_BODY;
               in_frame_in    = 1'b1;
               depth_in       = DEPTH_BITS'(1);
               in_string_in   = 1'b0;
               prev_bslash_in = 1'b0;
               length_in      = LENGTH_BITS'(1);
            end
         end
      end else if (limit_hit) begin
         status         = STATUS_ABORT;
         in_frame_in    = 1'b0;
         in_string_in   = 1'b0;
         prev_bslash_in = 1'b0;
         depth_in       = '0;
         length_in      = '0;
      end else begin
         status         = STATUS_BODY;
         length_in      = length_inc;
         prev_bslash_in = (data_byte == CH_BSLASH);
         if (data_byte == CH_QUOTE) begin
            if (!in_string_ff) begin
               in_string_in = 1'b1;
            end else if (!prev_bslash_ff) begin
               in_string_in = 1'b0;
            end
         end else if (!in_string_ff) begin
            if (data_byte == CH_OPEN) begin
               if (depth_ff >= DEPTH_MAX) begin
                  status         = STATUS_ABORT;
                  in_frame_in    = 1'b0;
                  prev_bslash_in = 1'b0;
                  depth_in       = '0;
                  length_in      = '0;
               end else begin
                  depth_in = depth_ff + DEPTH_BITS'(1);
               end
            end else if (data_byte == CH_CLOSE) begin
               if (depth_ff <= DEPTH_BITS'(1)) begin
                  status         = STATUS_END;
                  in_frame_in    = 1'b0;
                  prev_bslash_in = 1'b0;
                  depth_in       = '0;
                  length_in      = '0;
               end else begin
                  depth_in = depth_ff - DEPTH_BITS'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff    <= 1'b0;
         in_string_ff   <= 1'b0;
         prev_bslash_ff <= 1'b0;
         depth_ff       <= '0;
         length_ff      <= '0;
      end else if (push) begin
         in_frame_ff    <= in_frame_in;
         in_string_ff   <= in_string_in;
         prev_bslash_ff <= prev_bslash_in;
         depth_ff       <= depth_in;
         length_ff      <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= 16'd0;
      end else if (csr_write_enable) begin
         max_length_ff <= csr_write_data;
      end
   end

   assign result.data           = data_byte;
   assign result.status         = status;
   assign frame_state.in_frame  = in_frame_ff;
   assign frame_state.in_string = in_string_ff;
   assign frame_state.depth     = depth_ff;

endmodule
`default_nettype wire

// File: hw/rtl/jod_out_buffer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// JSON object deframer output buffer
// Result register with a skid entry, so that a request is taken while a
// finished result still waits on a stalled response channel.
// ----------------------------------------------------------------------------
module jod_out_buffer
   import jod_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire result_type push_data,
   output logic            full,
   output logic            out_valid,
   input  wire logic       out_stall,
   output result_type      out_data
);

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_ff, out_in;
   result_type skid_ff, skid_in;
   logic       take;

   assign take = out_valid_ff && !out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (!out_valid_ff || take) begin
         out_valid_in  = skid_valid_ff || push;
         skid_valid_in = 1'b0;
         out_in        = skid_valid_ff ? skid_ff : push_data;
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full      = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule
`default_nettype wire
